[hw/rtl/mwas_pkg.sv]
// Shared types and constants for the max-weight assignment solver.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package mwas_pkg;
    localparam int MAX_SIZE = 16;
    localparam int IDX_W    = $clog2(MAX_SIZE);
    localparam int CNT_W    = IDX_W + 1;
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
    localparam int WT_W     = 31;
    localparam int LBL_W    = 40;
    localparam int SLK_W    = 41;
    localparam int SZ_W     = 5;

    typedef enum logic [3:0] {
        S_IDLE, S_MAX_RD, S_MAX_USE, S_QINIT, S_PHASE, S_POP, S_SCAN_RD,
        S_SCAN_USE, S_MIN, S_MIN_DONE, S_UPD, S_AUG, S_KNEXT, S_OUT
    } state_t;

    typedef enum logic [3:0] {
        C_NOP, C_LOAD, C_MAX_USE, C_QINIT, C_PHASE, C_POP, C_SCAN_RD, C_SCAN_USE,
        C_MIN, C_UPD, C_AUG, C_KNEXT, C_EMIT
    } cmd_t;

    typedef struct packed {
        logic load_final;
        logic last_i;
        logic last_j;
        logic last_k;
        logic phase_over;
        logic pop_ok;
        logic v_valid;
        logic scan_stop;
        logic have;
        logic aug_go;
        logic out_free;
    } status_t;
endpackage

[hw/rtl/mwas_datapath.sv]
// Datapath: weight memory, labels, slacks, matching, search queue, output register.
// Executes one command per cycle from mwas_controller; depends on mwas_pkg.
`timescale 1ns / 1ps
module mwas_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mwas_pkg::cmd_t              cmd,
    output mwas_pkg::status_t           status,
    input  logic                        in_fire,
    input  logic [mwas_pkg::WT_W-1:0]   in_weight,
    input  logic                        in_final,
    input  logic                        cfg_fire,
    input  logic [mwas_pkg::SZ_W-1:0]   cfg_value,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [mwas_pkg::IDX_W-1:0]  out_row,
    output logic [mwas_pkg::IDX_W-1:0]  out_col,
    output logic                        out_last
);
    import mwas_pkg::*;

    logic signed [WT_W-1:0]  mem [DEPTH];
    logic signed [WT_W-1:0]  mem_q_reg;
    logic [ADDR_W-1:0]       ptr_reg;
    logic [SZ_W-1:0]         size_reg;
    logic [CNT_W-1:0]        n_reg, i_reg, j_reg, k_reg, phase_reg, qb_reg, qe_reg;
    logic [IDX_W-1:0]        r_reg;
    logic [CNT_W-1:0]        v_reg;
    logic signed [WT_W-1:0]  best_reg;
    logic signed [LBL_W-1:0] rlr_reg;
    logic signed [SLK_W-1:0] x_reg;
    logic                    have_reg;
    logic signed [LBL_W-1:0] rl [MAX_SIZE];
    logic signed [LBL_W-1:0] cl [MAX_SIZE];
    logic [CNT_W-1:0]        rp [MAX_SIZE];
    logic [CNT_W-1:0]        cp [MAX_SIZE];
    logic signed [SLK_W-1:0] cs [MAX_SIZE];
    logic [IDX_W-1:0]        par [MAX_SIZE];
    logic [IDX_W-1:0]        queue [MAX_SIZE];
    logic [MAX_SIZE-1:0]     ss_reg, rm_reg, cm_reg;

    logic [IDX_W-1:0]        ii, jj;
    logic [2*CNT_W-1:0]      prod;
    logic [2*CNT_W-1:0]      addr_sum;
    logic [ADDR_W-1:0]       rd_addr;
    logic [SZ_W-1:0]         eff_n;
    logic signed [WT_W-1:0]  best_next;
    logic signed [SLK_W-1:0] d;
    logic                    scan_take, scan_found;
    logic signed [SLK_W-1:0] cs_dec;
    logic [CNT_W-1:0]        qe_base;
    logic [IDX_W-1:0]        vv, pp;
    logic                    none_v;

    assign ii = i_reg[IDX_W-1:0];
    assign jj = j_reg[IDX_W-1:0];
    assign prod = (cmd == C_SCAN_USE || cmd == C_SCAN_RD) ? (2*CNT_W)'(r_reg) * (2*CNT_W)'(n_reg)
                                                          : (2*CNT_W)'(ii) * (2*CNT_W)'(n_reg);
    assign addr_sum = prod + (2*CNT_W)'(jj);
    assign rd_addr = addr_sum[ADDR_W-1:0];

    always_comb
    begin
        eff_n = size_reg;
        if (size_reg == '0)
            eff_n = SZ_W'(1);
        else if (size_reg > SZ_W'(MAX_SIZE))
            eff_n = SZ_W'(MAX_SIZE);
    end

    assign best_next = (j_reg == '0 || mem_q_reg > best_reg) ? mem_q_reg : best_reg;
    assign d = SLK_W'(rlr_reg) + SLK_W'(cl[jj]) - SLK_W'(mem_q_reg);
    assign scan_take = !cm_reg[jj] && (!ss_reg[jj] || cs[jj] > d);
    assign scan_found = scan_take && d == '0 && cp[jj][IDX_W];
    assign cs_dec = cs[jj] - x_reg;
    assign qe_base = (i_reg == '0) ? '0 : qe_reg;
    assign vv = v_reg[IDX_W-1:0];
    assign pp = par[vv];
    assign none_v = v_reg[IDX_W];

    assign status.load_final = in_fire && in_final;
    assign status.last_i     = (i_reg == n_reg - CNT_W'(1));
    assign status.last_j     = (j_reg == n_reg - CNT_W'(1));
    assign status.last_k     = (k_reg == n_reg - CNT_W'(1));
    assign status.phase_over = (phase_reg > n_reg);
    assign status.pop_ok     = (qb_reg < qe_reg) && none_v;
    assign status.v_valid    = !none_v;
    assign status.scan_stop  = status.last_j || scan_found;
    assign status.have       = have_reg;
    assign status.aug_go     = !none_v && (i_reg <= n_reg);
    assign status.out_free   = !out_valid || out_ready;

    always_ff @(posedge clk)
    begin
        if (in_fire)
            mem[ptr_reg] <= in_weight;
        mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            size_reg  <= SZ_W'(MAX_SIZE);
            n_reg     <= CNT_W'(MAX_SIZE);
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            phase_reg <= '0;
            qb_reg    <= '0;
            qe_reg    <= '0;
            v_reg     <= {1'b1, {IDX_W{1'b0}}};
            have_reg  <= 1'b0;
            ss_reg    <= '0;
            rm_reg    <= '0;
            cm_reg    <= '0;
            out_valid <= 1'b0;
            for (int t = 0; t < MAX_SIZE; t++)
            begin
                rp[t] <= {1'b1, {IDX_W{1'b0}}};
                cp[t] <= {1'b1, {IDX_W{1'b0}}};
            end
        end
        else
        begin
            if (cfg_fire)
                size_reg <= cfg_value;
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            case (cmd)
                C_LOAD:
                begin
                    if (in_fire)
                    begin
                        ptr_reg <= in_final ? '0 : ptr_reg + ADDR_W'(1);
                        if (in_final)
                        begin
                            n_reg <= CNT_W'(eff_n);
                            i_reg <= '0;
                            j_reg <= '0;
                        end
                    end
                end
                C_MAX_USE:
                begin
                    best_reg <= best_next;
                    if (status.last_j)
                    begin
                        rl[ii] <= LBL_W'(best_next);
                        cl[ii] <= '0;
                        rp[ii] <= {1'b1, {IDX_W{1'b0}}};
                        cp[ii] <= {1'b1, {IDX_W{1'b0}}};
                        j_reg  <= '0;
                        i_reg  <= status.last_i ? '0 : i_reg + CNT_W'(1);
                        if (status.last_i)
                            k_reg <= '0;
                    end
                    else
                        j_reg <= j_reg + CNT_W'(1);
                end
                C_QINIT:
                begin
                    if (i_reg == '0)
                    begin
                        rm_reg    <= '0;
                        cm_reg    <= '0;
                        ss_reg    <= '0;
                        qb_reg    <= '0;
                        phase_reg <= '0;
                        v_reg     <= {1'b1, {IDX_W{1'b0}}};
                    end
                    if (rp[ii][IDX_W] && qe_base < CNT_W'(MAX_SIZE))
                    begin
                        queue[qe_base[IDX_W-1:0]] <= ii;
                        qe_reg <= qe_base + CNT_W'(1);
                    end
                    else
                        qe_reg <= qe_base;
                    i_reg <= status.last_i ? '0 : i_reg + CNT_W'(1);
                end
                C_PHASE:
                begin
                    have_reg <= 1'b0;
                    x_reg    <= '0;
                end
                C_POP:
                begin
                    j_reg <= '0;
                    if (status.pop_ok)
                    begin
                        r_reg   <= queue[qb_reg[IDX_W-1:0]];
                        rlr_reg <= rl[queue[qb_reg[IDX_W-1:0]]];
                        rm_reg[queue[qb_reg[IDX_W-1:0]]] <= 1'b1;
                        qb_reg  <= qb_reg + CNT_W'(1);
                    end
                end
                C_SCAN_USE:
                begin
                    j_reg <= j_reg + CNT_W'(1);
                    if (scan_take)
                    begin
                        cs[jj]     <= d;
                        ss_reg[jj] <= 1'b1;
                        par[jj]    <= r_reg;
                        if (d == '0)
                        begin
                            cm_reg[jj] <= 1'b1;
                            if (!cp[jj][IDX_W])
                            begin
                                if (qe_reg < CNT_W'(MAX_SIZE))
                                begin
                                    queue[qe_reg[IDX_W-1:0]] <= cp[jj][IDX_W-1:0];
                                    qe_reg <= qe_reg + CNT_W'(1);
                                end
                            end
                            else
                                v_reg <= CNT_W'(jj);
                        end
                    end
                end
                C_MIN:
                begin
                    if (!cm_reg[jj] && ss_reg[jj] && (!have_reg || cs[jj] < x_reg))
                    begin
                        x_reg    <= cs[jj];
                        have_reg <= 1'b1;
                    end
                    j_reg <= status.last_j ? '0 : j_reg + CNT_W'(1);
                end
                C_UPD:
                begin
                    if (rm_reg[jj])
                        rl[jj] <= rl[jj] - LBL_W'(x_reg);
                    if (cm_reg[jj])
                        cl[jj] <= cl[jj] + LBL_W'(x_reg);
                    else if (ss_reg[jj])
                    begin
                        cs[jj] <= cs_dec;
                        if (cs_dec == '0)
                        begin
                            cm_reg[jj] <= 1'b1;
                            if (!cp[jj][IDX_W])
                            begin
                                if (qe_reg < CNT_W'(MAX_SIZE))
                                begin
                                    queue[qe_reg[IDX_W-1:0]] <= cp[jj][IDX_W-1:0];
                                    qe_reg <= qe_reg + CNT_W'(1);
                                end
                            end
                            else
                                v_reg <= CNT_W'(jj);
                        end
                    end
                    if (status.last_j)
                    begin
                        j_reg     <= '0;
                        phase_reg <= phase_reg + CNT_W'(1);
                    end
                    else
                        j_reg <= j_reg + CNT_W'(1);
                end
                C_AUG:
                begin
                    if (status.aug_go)
                    begin
                        rp[pp] <= CNT_W'(vv);
                        cp[vv] <= CNT_W'(pp);
                        v_reg  <= rp[pp];
                        i_reg  <= i_reg + CNT_W'(1);
                    end
                end
                C_KNEXT:
                begin
                    i_reg <= '0;
                    k_reg <= k_reg + CNT_W'(1);
                end
                C_EMIT:
                begin
                    if (status.out_free)
                    begin
                        out_valid <= 1'b1;
                        out_row   <= ii;
                        out_col   <= rp[ii][IDX_W] ? '0 : rp[ii][IDX_W-1:0];
                        out_last  <= status.last_i;
                        i_reg     <= status.last_i ? '0 : i_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule

[hw/rtl/mwas_controller.sv]
// Controller state machine for the assignment solver.
// Issues one datapath command per cycle from status flags; depends on mwas_pkg.
`timescale 1ns / 1ps
module mwas_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  mwas_pkg::status_t   status,
    output mwas_pkg::cmd_t      cmd,
    output mwas_pkg::state_t    state
);
    import mwas_pkg::*;

    state_t state_reg, state_next;

    assign state = state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (status.load_final) state_next = S_MAX_RD;
            S_MAX_RD:   state_next = S_MAX_USE;
            S_MAX_USE:  state_next = (status.last_j && status.last_i) ? S_QINIT : S_MAX_RD;
            S_QINIT:    if (status.last_i) state_next = S_PHASE;
            S_PHASE:    state_next = status.phase_over ? S_AUG : S_POP;
            S_POP:
            begin
                if (status.pop_ok)
                    state_next = S_SCAN_RD;
                else if (status.v_valid)
                    state_next = S_AUG;
                else
                    state_next = S_MIN;
            end
            S_SCAN_RD:  state_next = S_SCAN_USE;
            S_SCAN_USE: state_next = status.scan_stop ? S_POP : S_SCAN_RD;
            S_MIN:      if (status.last_j) state_next = S_MIN_DONE;
            S_MIN_DONE: state_next = status.have ? S_UPD : S_AUG;
            S_UPD:      if (status.last_j) state_next = S_PHASE;
            S_AUG:      if (!status.aug_go) state_next = S_KNEXT;
            S_KNEXT:    state_next = status.last_k ? S_OUT : S_QINIT;
            S_OUT:      if (status.out_free && status.last_i) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = C_NOP;
        case (state_reg)
            S_IDLE:     cmd = in_fire ? C_LOAD : C_NOP;
            S_MAX_USE:  cmd = C_MAX_USE;
            S_QINIT:    cmd = C_QINIT;
            S_PHASE:    cmd = C_PHASE;
            S_POP:      cmd = C_POP;
            S_SCAN_RD:  cmd = C_SCAN_RD;
            S_SCAN_USE: cmd = C_SCAN_USE;
            S_MIN:      cmd = C_MIN;
            S_UPD:      cmd = C_UPD;
            S_AUG:      cmd = C_AUG;
            S_KNEXT:    cmd = C_KNEXT;
            S_OUT:      cmd = C_EMIT;
            default:    cmd = C_NOP;
        endcase
    end
endmodule

[hw/rtl/max_weight_assignment_solver.sv]
// Max-weight assignment solver: loads an n-by-n weight matrix, one item per cycle.
// After the final weight, the controller steps the search column by column, and the
// scan reads each weight from the memory port in a read state before it uses it.
// Throughput: one weight per cycle while loading; input stalls during solve and output.
// Results: n items, one per cycle when the sink is ready. Reset: async, active low,
// clears control state and sets active_size to 16; the weight memory is not cleared.
`timescale 1ns / 1ps
module max_weight_assignment_solver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] weight, [31] zero pad
    input  logic        s_axis_tlast,   // final_weight
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [3:0] row_index, [7:4] matched_column
    output logic        m_axis_tlast,   // last_row
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data        // active_size
);
    import mwas_pkg::*;

    cmd_t             cmd;
    state_t           state;
    status_t          status;
    logic             in_fire;
    logic [IDX_W-1:0] out_row, out_col;

    assign s_axis_tready = (state == S_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign m_axis_tdata = {out_col, out_row};

    mwas_controller u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .status  (status),
        .cmd     (cmd),
        .state   (state)
    );

    mwas_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_fire   (in_fire),
        .in_weight (s_axis_tdata[WT_W-1:0]),
        .in_final  (s_axis_tlast),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_value (cfg_data),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_last  (m_axis_tlast)
    );

    a_final_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s_axis_tlast |=> !s_axis_tready)
        else $error("input accepted right after final weight");

    a_idle_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_axis_tready) |-> $past(state) == S_OUT)
        else $error("returned to idle without reporting results");
endmodule
